FILE: src/scc_pkg.sv
// Shared widths and constants for the sphere/capsule contact pipeline.
package scc_pkg;

  localparam int FRAC_BITS = 16;   // fraction bits of all coordinates
  localparam int CW        = 32;   // coordinate width
  localparam int RADW      = 31;   // radius width
  localparam int NW        = 18;   // normal component width
  localparam int EPSW      = 16;   // fuzzy epsilon width
  localparam int LW        = 66;   // squared length width, |n|^2 < 3*2^64

  localparam logic [EPSW-1:0] EPS_RESET = 16'd1;

endpackage

FILE: src/scc_if.sv
// Valid/ready channels: sphere/capsule pair in, contact result out.
interface scc_pair_if;
  logic                          valid;
  logic                          ready;
  logic signed [scc_pkg::CW-1:0] sphere_x;
  logic signed [scc_pkg::CW-1:0] sphere_y;
  logic signed [scc_pkg::CW-1:0] sphere_z;
  logic [scc_pkg::RADW-1:0]      sphere_radius;
  logic signed [scc_pkg::CW-1:0] seg_a_x;
  logic signed [scc_pkg::CW-1:0] seg_a_y;
  logic signed [scc_pkg::CW-1:0] seg_a_z;
  logic signed [scc_pkg::CW-1:0] seg_b_x;
  logic signed [scc_pkg::CW-1:0] seg_b_y;
  logic signed [scc_pkg::CW-1:0] seg_b_z;
  logic [scc_pkg::RADW-1:0]      capsule_radius;

  modport source (
    output valid, sphere_x, sphere_y, sphere_z, sphere_radius,
           seg_a_x, seg_a_y, seg_a_z, seg_b_x, seg_b_y, seg_b_z, capsule_radius,
    input  ready
  );
  modport sink (
    input  valid, sphere_x, sphere_y, sphere_z, sphere_radius,
           seg_a_x, seg_a_y, seg_a_z, seg_b_x, seg_b_y, seg_b_z, capsule_radius,
    output ready
  );
endinterface

interface scc_contact_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic                          degenerate;
  logic signed [scc_pkg::NW-1:0] normal_x;
  logic signed [scc_pkg::NW-1:0] normal_y;
  logic signed [scc_pkg::NW-1:0] normal_z;
  logic signed [scc_pkg::CW-1:0] contact_x;
  logic signed [scc_pkg::CW-1:0] contact_y;
  logic signed [scc_pkg::CW-1:0] contact_z;
  logic signed [scc_pkg::CW-1:0] penetration;

  modport source (
    output valid, hit, degenerate, normal_x, normal_y, normal_z,
           contact_x, contact_y, contact_z, penetration,
    input  ready
  );
  modport sink (
    input  valid, hit, degenerate, normal_x, normal_y, normal_z,
           contact_x, contact_y, contact_z, penetration,
    output ready
  );
endinterface

FILE: src/scc_isqrt.sv
// Pipelined floor integer square root, one root bit per stage.
module scc_isqrt #(
  parameter int XW = scc_pkg::LW
) (
  input  logic            clk,
  input  logic            en,
  input  logic [XW-1:0]   radicand,
  output logic [XW/2-1:0] root
);

  localparam int RW = XW / 2;

  logic [XW-1:0] op_r  [RW];
  logic [XW-1:0] res_r [RW];

  for (genvar i = 0; i < RW; i++) begin : g_step
    localparam logic [XW-1:0] ONE = {{(XW-1){1'b0}}, 1'b1} << (2 * (RW - 1 - i));
    logic [XW-1:0] op_in;
    logic [XW-1:0] res_in;
    logic [XW-1:0] trial;

    if (i == 0) begin : g_first
      assign op_in  = radicand;
      assign res_in = '0;
    end else begin : g_next
      assign op_in  = op_r[i-1];
      assign res_in = res_r[i-1];
    end

    assign trial = res_in + ONE;

    always_ff @(posedge clk) begin
      if (en) begin
        if (op_in >= trial) begin
          op_r[i]  <= op_in - trial;
          res_r[i] <= (res_in >> 1) + ONE;
        end else begin
          op_r[i]  <= op_in;
          res_r[i] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res_r[RW-1][RW-1:0];

endmodule

FILE: src/sphere_capsule_contact.sv
// Sphere/capsule contact test: fully pipelined, one pair per clock if unstalled.
//
// Input channel "pair" carries one sphere (center, radius) and one capsule
// (segment endpoints, radius) in signed fixed point with FRAC_BITS fraction
// bits. Output channel "result" carries hit, degenerate, the unit normal from
// sphere toward segment, the contact midpoint and the penetration depth.
// cfg_we/cfg_data write fuzzy_epsilon (reset value 1); write it only while
// no transfer is in flight.
//
// The projection divide takes FRAC_BITS stages, the square root one stage
// per root bit (33) and the normal divide FRAC_BITS+1 stages, one bit per
// stage. The pipeline takes one pair per cycle while the receiver is not
// stalling.
//
// Reset clears all stage valid bits and sets fuzzy_epsilon to 1. When the
// receiver stalls the whole pipeline holds; pair.ready drops only while the
// last stage holds a result that is not taken, so nothing is lost.
module sphere_capsule_contact #(
  parameter int FRAC_BITS = scc_pkg::FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  scc_pair_if.sink                  pair,
  scc_contact_if.source             result,
  input  logic                      cfg_we,
  input  logic [scc_pkg::EPSW-1:0]  cfg_data
);

  localparam int F     = FRAC_BITS;
  localparam int CW    = scc_pkg::CW;
  localparam int RADW  = scc_pkg::RADW;
  localparam int LW    = scc_pkg::LW;
  localparam int RTW   = LW / 2;        // root width
  localparam int DW    = CW + 1;        // difference width
  localparam int PW    = 2 * DW;        // product of two differences
  localparam int DOTW  = PW + 1;
  localparam int DENW  = PW;
  localparam int NUMW  = DOTW;
  localparam int PRW   = DW + F + 1;
  localparam int ND    = F + 1;         // normal quotient bits
  localparam int NRW   = F + 2;
  localparam int RMW   = RTW + 1;
  localparam int MW    = NRW + CW;
  localparam int XW    = CW + 4;
  localparam int DEPTH = 12 + F + RTW + ND;

  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;
  localparam logic [1:0] SEL_T = 2'd2;

  localparam logic signed [39:0] SAT_MAX = 40'sd2147483647;
  localparam logic signed [39:0] SAT_MIN = -40'sd2147483648;

  function automatic logic signed [CW-1:0] sat32(input logic signed [39:0] v);
    logic signed [CW-1:0] r;
    if (v > SAT_MAX) r = SAT_MAX[CW-1:0];
    else if (v < SAT_MIN) r = SAT_MIN[CW-1:0];
    else r = v[CW-1:0];
    return r;
  endfunction

  logic en;
  logic [DEPTH-1:0] vld;
  logic [scc_pkg::EPSW-1:0] eps;
  logic [LW-1:0] epsw;

  assign en         = !vld[DEPTH-1] || result.ready;
  assign pair.ready = en;
  assign epsw       = LW'(eps) << F;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= scc_pkg::EPS_RESET;
    end else if (cfg_we) begin
      eps <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], pair.valid};
    end
  end

  logic signed [CW-1:0] in_p [3];
  logic signed [CW-1:0] in_a [3];
  logic signed [CW-1:0] in_b [3];

  assign in_p[0] = pair.sphere_x;
  assign in_p[1] = pair.sphere_y;
  assign in_p[2] = pair.sphere_z;
  assign in_a[0] = pair.seg_a_x;
  assign in_a[1] = pair.seg_a_y;
  assign in_a[2] = pair.seg_a_z;
  assign in_b[0] = pair.seg_b_x;
  assign in_b[1] = pair.seg_b_y;
  assign in_b[2] = pair.seg_b_z;

  // stage 1: differences
  logic signed [CW-1:0] s1_p [3], s1_a [3], s1_b [3];
  logic signed [DW-1:0] s1_d [3], s1_v [3];
  logic [RADW-1:0]      s1_rs, s1_rc;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_p[i] <= in_p[i];
        s1_a[i] <= in_a[i];
        s1_b[i] <= in_b[i];
        s1_d[i] <= DW'(in_b[i]) - DW'(in_a[i]);
        s1_v[i] <= DW'(in_p[i]) - DW'(in_a[i]);
      end
      s1_rs <= pair.sphere_radius;
      s1_rc <= pair.capsule_radius;
    end
  end

  // stage 2: products for projection
  logic signed [CW-1:0] s2_p [3], s2_a [3], s2_b [3];
  logic signed [DW-1:0] s2_d [3];
  logic signed [PW-1:0] s2_vd [3], s2_dd [3];
  logic [RADW-1:0]      s2_rs, s2_rc;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_p[i]  <= s1_p[i];
        s2_a[i]  <= s1_a[i];
        s2_b[i]  <= s1_b[i];
        s2_d[i]  <= s1_d[i];
        s2_vd[i] <= PW'(s1_v[i]) * PW'(s1_d[i]);
        s2_dd[i] <= PW'(s1_d[i]) * PW'(s1_d[i]);
      end
      s2_rs <= s1_rs;
      s2_rc <= s1_rc;
    end
  end

  // stage 3: dot product and squared segment length
  logic signed [CW-1:0]   s3_p [3], s3_a [3], s3_b [3];
  logic signed [DW-1:0]   s3_d [3];
  logic signed [DOTW-1:0] s3_dot;
  logic [DENW-1:0]        s3_den;
  logic [RADW-1:0]        s3_rs, s3_rc;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_p   <= s2_p;
      s3_a   <= s2_a;
      s3_b   <= s2_b;
      s3_d   <= s2_d;
      s3_dot <= DOTW'(s2_vd[0]) + DOTW'(s2_vd[1]) + DOTW'(s2_vd[2]);
      s3_den <= DENW'(s2_dd[0]) + DENW'(s2_dd[1]) + DENW'(s2_dd[2]);
      s3_rs  <= s2_rs;
      s3_rc  <= s2_rc;
    end
  end

  // stage 4: clamp decision
  logic signed [CW-1:0] s4_p [3], s4_a [3], s4_b [3];
  logic signed [DW-1:0] s4_d [3];
  logic [NUMW-1:0]      s4_num;
  logic [DENW-1:0]      s4_den;
  logic [1:0]           s4_sel;
  logic [RADW-1:0]      s4_rs, s4_rc;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_p   <= s3_p;
      s4_a   <= s3_a;
      s4_b   <= s3_b;
      s4_d   <= s3_d;
      s4_num <= NUMW'($unsigned(s3_dot));
      s4_den <= s3_den;
      s4_rs  <= s3_rs;
      s4_rc  <= s3_rc;
      if (s3_dot <= 0) begin
        s4_sel <= SEL_A;
      end else if (DOTW'(s3_den) <= $unsigned(s3_dot)) begin
        s4_sel <= SEL_B;
      end else begin
        s4_sel <= SEL_T;
      end
    end
  end

  // projection divide t = dot * 2^F / den, one bit per stage
  logic [NUMW-1:0]      dv_num [F];
  logic [F-1:0]         dv_t   [F];
  logic [DENW-1:0]      dv_den [F];
  logic signed [CW-1:0] dv_p [F][3], dv_a [F][3], dv_b [F][3];
  logic signed [DW-1:0] dv_d [F][3];
  logic [1:0]           dv_sel [F];
  logic [RADW-1:0]      dv_rs [F], dv_rc [F];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_den[0] <= s4_den;
      dv_p[0]   <= s4_p;
      dv_a[0]   <= s4_a;
      dv_b[0]   <= s4_b;
      dv_d[0]   <= s4_d;
      dv_sel[0] <= s4_sel;
      dv_rs[0]  <= s4_rs;
      dv_rc[0]  <= s4_rc;
      for (int k = 1; k < F; k++) begin
        dv_den[k] <= dv_den[k-1];
        dv_p[k]   <= dv_p[k-1];
        dv_a[k]   <= dv_a[k-1];
        dv_b[k]   <= dv_b[k-1];
        dv_d[k]   <= dv_d[k-1];
        dv_sel[k] <= dv_sel[k-1];
        dv_rs[k]  <= dv_rs[k-1];
        dv_rc[k]  <= dv_rc[k-1];
      end
    end
  end

  for (genvar k = 0; k < F; k++) begin : g_tdiv
    logic [NUMW-1:0] num_in;
    logic [NUMW-1:0] sh;
    logic [DENW-1:0] den_in;
    logic [F-1:0]    t_in;

    if (k == 0) begin : g_first
      assign num_in = s4_num;
      assign den_in = s4_den;
      assign t_in   = '0;
    end else begin : g_next
      assign num_in = dv_num[k-1];
      assign den_in = dv_den[k-1];
      assign t_in   = dv_t[k-1];
    end

    assign sh = num_in << 1;

    always_ff @(posedge clk) begin
      if (en) begin
        if (NUMW'(den_in) <= sh) begin
          dv_num[k] <= sh - NUMW'(den_in);
          dv_t[k]   <= {t_in[F-2:0], 1'b1};
        end else begin
          dv_num[k] <= sh;
          dv_t[k]   <= {t_in[F-2:0], 1'b0};
        end
      end
    end
  end

  // d * t
  logic signed [CW-1:0]  pr_p [3], pr_a [3], pr_b [3];
  logic signed [PRW-1:0] pr_m [3];
  logic [1:0]            pr_sel;
  logic [RADW-1:0]       pr_rs, pr_rc;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr_m[i] <= PRW'(dv_d[F-1][i]) * PRW'($signed({1'b0, dv_t[F-1]}));
      end
      pr_p   <= dv_p[F-1];
      pr_a   <= dv_a[F-1];
      pr_b   <= dv_b[F-1];
      pr_sel <= dv_sel[F-1];
      pr_rs  <= dv_rs[F-1];
      pr_rc  <= dv_rc[F-1];
    end
  end

  // closest point on segment; it lies between the endpoints, so CW bits hold it
  logic signed [CW-1:0] cl_p [3], cl_c [3];
  logic [RADW-1:0]      cl_rs, cl_rc;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        case (pr_sel)
          SEL_A:   cl_c[i] <= pr_a[i];
          SEL_B:   cl_c[i] <= pr_b[i];
          SEL_T:   cl_c[i] <= pr_a[i] + CW'(pr_m[i] >>> F);
          default: cl_c[i] <= pr_a[i];
        endcase
      end
      cl_p  <= pr_p;
      cl_rs <= pr_rs;
      cl_rc <= pr_rc;
    end
  end

  // n = closest - center
  logic signed [CW-1:0] nv_p [3], nv_c [3];
  logic signed [DW-1:0] nv_n [3];
  logic [RADW-1:0]      nv_rs, nv_rc;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nv_n[i] <= DW'(cl_c[i]) - DW'(cl_p[i]);
      end
      nv_p  <= cl_p;
      nv_c  <= cl_c;
      nv_rs <= cl_rs;
      nv_rc <= cl_rc;
    end
  end

  // squares of n, radius sum
  logic signed [CW-1:0] qs_p [3], qs_c [3];
  logic signed [DW-1:0] qs_n [3];
  logic signed [PW-1:0] qs_sq [3];
  logic [RADW-1:0]      qs_rs, qs_rc;
  logic [CW-1:0]        qs_rsum;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        qs_sq[i] <= PW'(nv_n[i]) * PW'(nv_n[i]);
      end
      qs_p    <= nv_p;
      qs_c    <= nv_c;
      qs_n    <= nv_n;
      qs_rs   <= nv_rs;
      qs_rc   <= nv_rc;
      qs_rsum <= CW'(nv_rs) + CW'(nv_rc);
    end
  end

  // squared distance, squared radius sum
  logic signed [CW-1:0] ls_p [3], ls_c [3];
  logic signed [DW-1:0] ls_n [3];
  logic [LW-1:0]        ls_len;
  logic [2*CW-1:0]      ls_rsq;
  logic [RADW-1:0]      ls_rs, ls_rc;
  logic [CW-1:0]        ls_rsum;

  always_ff @(posedge clk) begin
    if (en) begin
      ls_len  <= LW'(qs_sq[0]) + LW'(qs_sq[1]) + LW'(qs_sq[2]);
      ls_rsq  <= (2*CW)'(qs_rsum) * (2*CW)'(qs_rsum);
      ls_p    <= qs_p;
      ls_c    <= qs_c;
      ls_n    <= qs_n;
      ls_rs   <= qs_rs;
      ls_rc   <= qs_rc;
      ls_rsum <= qs_rsum;
    end
  end

  // contact and degenerate tests, split n into sign and magnitude
  logic signed [CW-1:0] ts_p [3], ts_c [3];
  logic                 ts_neg [3];
  logic [DW-1:0]        ts_mag [3];
  logic [LW-1:0]        ts_len;
  logic [RADW-1:0]      ts_rs, ts_rc;
  logic [CW-1:0]        ts_rsum;
  logic                 ts_deg, ts_hit;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ts_neg[i] <= ls_n[i] < 0;
        ts_mag[i] <= DW'((ls_n[i] < 0) ? -ls_n[i] : ls_n[i]);
      end
      ts_deg  <= ls_len <= epsw;
      ts_hit  <= !(ls_len <= epsw) && (ls_len <= LW'(ls_rsq) + epsw);
      ts_len  <= ls_len;
      ts_p    <= ls_p;
      ts_c    <= ls_c;
      ts_rs   <= ls_rs;
      ts_rc   <= ls_rc;
      ts_rsum <= ls_rsum;
    end
  end

  // distance
  logic [RTW-1:0] root;

  scc_isqrt #(
    .XW (LW)
  ) u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (ts_len),
    .root     (root)
  );

  logic signed [CW-1:0] sq_p [RTW][3], sq_c [RTW][3];
  logic                 sq_neg [RTW][3];
  logic [DW-1:0]        sq_mag [RTW][3];
  logic [RADW-1:0]      sq_rs [RTW], sq_rc [RTW];
  logic [CW-1:0]        sq_rsum [RTW];
  logic                 sq_deg [RTW], sq_hit [RTW];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_p[0]    <= ts_p;
      sq_c[0]    <= ts_c;
      sq_neg[0]  <= ts_neg;
      sq_mag[0]  <= ts_mag;
      sq_rs[0]   <= ts_rs;
      sq_rc[0]   <= ts_rc;
      sq_rsum[0] <= ts_rsum;
      sq_deg[0]  <= ts_deg;
      sq_hit[0]  <= ts_hit;
      for (int k = 1; k < RTW; k++) begin
        sq_p[k]    <= sq_p[k-1];
        sq_c[k]    <= sq_c[k-1];
        sq_neg[k]  <= sq_neg[k-1];
        sq_mag[k]  <= sq_mag[k-1];
        sq_rs[k]   <= sq_rs[k-1];
        sq_rc[k]   <= sq_rc[k-1];
        sq_rsum[k] <= sq_rsum[k-1];
        sq_deg[k]  <= sq_deg[k-1];
        sq_hit[k]  <= sq_hit[k-1];
      end
    end
  end

  // normal divide |n| * 2^F / dist; |n| <= dist so the first bit has weight 2^F
  logic [RMW-1:0]       nd_r [ND][3];
  logic [ND-1:0]        nd_q [ND][3];
  logic [RTW-1:0]       nd_dist [ND];
  logic signed [CW-1:0] nd_p [ND][3], nd_c [ND][3];
  logic                 nd_neg [ND][3];
  logic [RADW-1:0]      nd_rs [ND], nd_rc [ND];
  logic [CW-1:0]        nd_rsum [ND];
  logic                 nd_deg [ND], nd_hit [ND];

  always_ff @(posedge clk) begin
    if (en) begin
      nd_dist[0] <= root;
      nd_p[0]    <= sq_p[RTW-1];
      nd_c[0]    <= sq_c[RTW-1];
      nd_neg[0]  <= sq_neg[RTW-1];
      nd_rs[0]   <= sq_rs[RTW-1];
      nd_rc[0]   <= sq_rc[RTW-1];
      nd_rsum[0] <= sq_rsum[RTW-1];
      nd_deg[0]  <= sq_deg[RTW-1];
      nd_hit[0]  <= sq_hit[RTW-1];
      for (int k = 1; k < ND; k++) begin
        nd_dist[k] <= nd_dist[k-1];
        nd_p[k]    <= nd_p[k-1];
        nd_c[k]    <= nd_c[k-1];
        nd_neg[k]  <= nd_neg[k-1];
        nd_rs[k]   <= nd_rs[k-1];
        nd_rc[k]   <= nd_rc[k-1];
        nd_rsum[k] <= nd_rsum[k-1];
        nd_deg[k]  <= nd_deg[k-1];
        nd_hit[k]  <= nd_hit[k-1];
      end
    end
  end

  for (genvar j = 0; j < ND; j++) begin : g_ndiv
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [RMW-1:0] r_in;
      logic [RMW-1:0] d_in;
      logic [ND-1:0]  q_in;

      if (j == 0) begin : g_first
        assign r_in = RMW'(sq_mag[RTW-1][i]);
        assign d_in = RMW'(root);
        assign q_in = '0;
      end else begin : g_next
        assign r_in = nd_r[j-1][i] << 1;
        assign d_in = RMW'(nd_dist[j-1]);
        assign q_in = nd_q[j-1][i];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          if (r_in >= d_in) begin
            nd_r[j][i] <= r_in - d_in;
            nd_q[j][i] <= {q_in[ND-2:0], 1'b1};
          end else begin
            nd_r[j][i] <= r_in;
            nd_q[j][i] <= {q_in[ND-2:0], 1'b0};
          end
        end
      end
    end
  end

  // signed normal, surface offsets
  logic signed [NRW-1:0] nrm [3];
  logic signed [NRW-1:0] mu_nrm [3];
  logic signed [MW-1:0]  mu_ms [3], mu_mc [3];
  logic signed [CW-1:0]  mu_p [3], mu_c [3];
  logic [RTW-1:0]        mu_dist;
  logic [CW-1:0]         mu_rsum;
  logic                  mu_deg, mu_hit;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm[i] = nd_neg[ND-1][i] ? -$signed({1'b0, nd_q[ND-1][i]})
                               : $signed({1'b0, nd_q[ND-1][i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mu_ms[i] <= MW'(nrm[i]) * MW'($signed({1'b0, nd_rs[ND-1]}));
        mu_mc[i] <= MW'(nrm[i]) * MW'($signed({1'b0, nd_rc[ND-1]}));
      end
      mu_nrm  <= nrm;
      mu_p    <= nd_p[ND-1];
      mu_c    <= nd_c[ND-1];
      mu_dist <= nd_dist[ND-1];
      mu_rsum <= nd_rsum[ND-1];
      mu_deg  <= nd_deg[ND-1];
      mu_hit  <= nd_hit[ND-1];
    end
  end

  // contact midpoint, penetration, output register
  logic signed [XW-1:0] sp [3], cp [3], mid [3];
  logic                 o_hit, o_deg;
  logic signed [scc_pkg::NW-1:0] o_nrm [3];
  logic signed [CW-1:0] o_ct [3];
  logic signed [CW-1:0] o_pen;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sp[i]  = XW'(mu_p[i]) + XW'(mu_ms[i] >>> F);
      cp[i]  = XW'(mu_c[i]) - XW'(mu_mc[i] >>> F);
      mid[i] = (sp[i] + cp[i]) >>> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_hit <= mu_hit;
      o_deg <= mu_deg;
      for (int i = 0; i < 3; i++) begin
        o_nrm[i] <= mu_hit ? scc_pkg::NW'(mu_nrm[i]) : '0;
        o_ct[i]  <= mu_hit ? sat32(40'(mid[i])) : '0;
      end
      o_pen <= mu_hit ? sat32($signed(40'(mu_rsum) - 40'(mu_dist))) : '0;
    end
  end

  assign result.valid       = vld[DEPTH-1];
  assign result.hit         = o_hit;
  assign result.degenerate  = o_deg;
  assign result.normal_x    = o_nrm[0];
  assign result.normal_y    = o_nrm[1];
  assign result.normal_z    = o_nrm[2];
  assign result.contact_x   = o_ct[0];
  assign result.contact_y   = o_ct[1];
  assign result.contact_z   = o_ct[2];
  assign result.penetration = o_pen;

endmodule

FILE: src/scc_checker.sv
// Port-level checks for the sphere/capsule contact block, bound to the top.
module scc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          hit,
  input logic                          degenerate,
  input logic signed [scc_pkg::NW-1:0] normal_x,
  input logic signed [scc_pkg::CW-1:0] contact_x,
  input logic signed [scc_pkg::CW-1:0] penetration
);

  // result held while receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped during stall");

  // pipeline empty right after reset
  a_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

  // an empty output stage never blocks the input side
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && degenerate))
    else $error("hit and degenerate both set");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> normal_x == 0 && contact_x == 0 && penetration == 0)
    else $error("nonzero fields without contact");

endmodule

bind sphere_capsule_contact scc_checker u_scc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (pair.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .hit         (result.hit),
  .degenerate  (result.degenerate),
  .normal_x    (result.normal_x),
  .contact_x   (result.contact_x),
  .penetration (result.penetration)
);
